// ----- hw/rtl/optical_line_frame_receiver_macros.svh -----
// assertion macros shared by the optical line frame receiver checkers
// depends on nothing; included by the checker file
`ifndef OPTICAL_LINE_FRAME_RECEIVER_MACROS_SVH
`define OPTICAL_LINE_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, reset masks the check
`define OLFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olfr assertion failed");

// next-cycle implication, reset masks the check
`define OLFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olfr assertion failed");

`endif

// ----- hw/rtl/olfr_pkg.sv -----
`timescale 1ns / 1ps
// types, constants and helpers for the optical line frame receiver
// used by olfr_core and optical_line_frame_receiver
package olfr_pkg;

    localparam int TIMER_WIDTH     = 16;
    localparam int MAX_FRAME_BYTES = 64;
    localparam int FRAME_W         = 7;
    localparam int INDEX_W         = 6;
    localparam int VOTE_MAJORITY   = 2;

    localparam logic [TIMER_WIDTH-1:0] HEADER_TICKS_RST = TIMER_WIDTH'(1000);
    localparam logic [TIMER_WIDTH-1:0] SKIP_TICKS_RST   = TIMER_WIDTH'(300);
    localparam logic [TIMER_WIDTH-1:0] SAMPLE_TICKS_RST = TIMER_WIDTH'(25);
    localparam logic [FRAME_W-1:0]     FRAME_BYTES_RST  = FRAME_W'(16);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_HEADER  = 2'd1,
        MODE_SKIP    = 2'd2,
        MODE_RECEIVE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_HEADER_TICKS = 2'd0,
        REG_SKIP_TICKS   = 2'd1,
        REG_SAMPLE_TICKS = 2'd2,
        REG_FRAME_BYTES  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TIMER_WIDTH-1:0] header_ticks;
        logic [TIMER_WIDTH-1:0] skip_ticks;
        logic [TIMER_WIDTH-1:0] sample_ticks;
        logic [FRAME_W-1:0]     frame_bytes;
    } cfg_t;

    typedef struct packed {
        mode_t                  mode;
        logic                   prev_level;
        logic [TIMER_WIDTH-1:0] tick_timer;
        logic [1:0]             sample_number;
        logic [2:0]             ones_seen;
        logic [2:0]             bit_position;
        logic [7:0]             byte_shift;
        logic [FRAME_W-1:0]     bytes_done;
    } rx_state_t;

    typedef struct packed {
        logic               valid;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last_byte;
    } rx_result_t;

    function automatic logic [FRAME_W-1:0] frame_limit(input logic [FRAME_W-1:0] n);
        logic [FRAME_W-1:0] lim;
        lim = n;
        if (n == '0)
            lim = FRAME_W'(1);
        else if (n > FRAME_W'(MAX_FRAME_BYTES))
            lim = FRAME_W'(MAX_FRAME_BYTES);
        return lim;
    endfunction

    // wipe the per-frame fields, mode and edge tracking untouched
    function automatic rx_state_t clear_receive(input rx_state_t s);
        rx_state_t r;
        r               = s;
        r.tick_timer    = '0;
        r.sample_number = '0;
        r.ones_seen     = '0;
        r.bit_position  = 3'd7;
        r.byte_shift    = '0;
        r.bytes_done    = '0;
        return r;
    endfunction

endpackage

// ----- hw/rtl/optical_line_frame_receiver.sv -----
`timescale 1ns / 1ps
// top level of the optical line frame receiver: config registers, state, output register
// depends on olfr_pkg and olfr_core
//
// usage:
//   input channel (in_valid/in_ready, line_level) carries one line sample per
//   transaction; each transaction is one tick of the receiver's time base
//   output channel (out_valid/out_ready) carries one transaction per finished
//   byte: data_byte (first bit in bit 7), byte_index and last_byte
//   config port: cfg_write_en with cfg_index selects header_ticks, skip_ticks,
//   sample_ticks or frame_bytes; write only while no frame is in flight
//   output: a byte is registered and appears on the output in the cycle after
//   the sample that completes it is accepted
//   throughput: one sample per cycle while in_ready is high, set by the single state register update
//   stall: a waiting byte holds the output register; in_ready drops while it
//   waits and out_ready is low, and rises again in the cycle it is taken
//   reset: receiver goes idle, edge tracking sees a low line, config
//   registers return to 1000 / 300 / 25 / 16, no byte is pending
module optical_line_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        line_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic [5:0]  byte_index,
    output logic        last_byte
);

    olfr_pkg::cfg_t       cfg_reg;
    olfr_pkg::cfg_t       cfg_next;
    olfr_pkg::rx_state_t  state_reg;
    olfr_pkg::rx_state_t  state_next;
    olfr_pkg::rx_result_t result;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           data_byte_reg;
    logic [5:0]           byte_index_reg;
    logic                 last_byte_reg;
    logic                 in_fire;

    // a pending byte only blocks input when it cannot leave this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // register writes decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (olfr_pkg::cfg_idx_t'(cfg_index))
                olfr_pkg::REG_HEADER_TICKS: cfg_next.header_ticks = cfg_data;
                olfr_pkg::REG_SKIP_TICKS:   cfg_next.skip_ticks   = cfg_data;
                olfr_pkg::REG_SAMPLE_TICKS: cfg_next.sample_ticks = cfg_data;
                olfr_pkg::REG_FRAME_BYTES:
                    cfg_next.frame_bytes = cfg_data[olfr_pkg::FRAME_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_ticks <= olfr_pkg::HEADER_TICKS_RST;
            cfg_reg.skip_ticks   <= olfr_pkg::SKIP_TICKS_RST;
            cfg_reg.sample_ticks <= olfr_pkg::SAMPLE_TICKS_RST;
            cfg_reg.frame_bytes  <= olfr_pkg::FRAME_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // all per-sample work: edge detect, timers, vote, byte assembly
    olfr_core u_core
    (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .line_level (line_level),
        .state_next (state_next),
        .result     (result)
    );

    // receiver state advances once per accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= olfr_pkg::MODE_IDLE;
            state_reg.prev_level    <= 1'b0;
            state_reg.tick_timer    <= '0;
            state_reg.sample_number <= '0;
            state_reg.ones_seen     <= '0;
            state_reg.bit_position  <= 3'd7;
            state_reg.byte_shift    <= '0;
            state_reg.bytes_done    <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // output register: loaded on a byte, cleared once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = result.valid;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && result.valid)
        begin
            data_byte_reg  <= result.data_byte;
            byte_index_reg <= result.byte_index;
            last_byte_reg  <= result.last_byte;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign last_byte  = last_byte_reg;

endmodule

// ----- hw/rtl/olfr_core.sv -----
`timescale 1ns / 1ps
// next-state and result logic for one line sample of the frame receiver
// depends on olfr_pkg
module olfr_core
(
    input  olfr_pkg::rx_state_t  state,
    input  olfr_pkg::cfg_t       cfg,
    input  logic                 line_level,
    output olfr_pkg::rx_state_t  state_next,
    output olfr_pkg::rx_result_t result
);

    logic                                 rise;
    logic                                 in_receive;
    logic [olfr_pkg::TIMER_WIDTH-1:0]     timer_inc;
    logic [olfr_pkg::TIMER_WIDTH-1:0]     timer_eff;
    logic [olfr_pkg::TIMER_WIDTH-1:0]     timer_rx_inc;
    logic                                 sample_now;
    logic                                 bit_done;
    logic                                 byte_done;
    logic [2:0]                           ones_new;
    logic                                 vote;
    logic [7:0]                           shift_new;
    logic [olfr_pkg::FRAME_W-1:0]         bytes_new;
    logic                                 frame_last;

    // shared decode of where this sample lands
    always_comb
    begin
        rise       = line_level & ~state.prev_level;
        timer_inc  = state.tick_timer + 1'b1;
        in_receive = 1'b0;
        timer_eff  = state.tick_timer;
        unique case (state.mode)
            olfr_pkg::MODE_SKIP:
            begin
                if (state.tick_timer >= cfg.skip_ticks)
                begin
                    in_receive = 1'b1;
                    timer_eff  = '0;
                end
            end
            olfr_pkg::MODE_RECEIVE: in_receive = 1'b1;
            default:                in_receive = 1'b0;
        endcase
        timer_rx_inc = timer_eff + 1'b1;
        sample_now   = in_receive && (timer_eff == '0);
        ones_new     = state.ones_seen + 3'(line_level);
        bit_done     = sample_now && (state.sample_number == 2'd3);
        byte_done    = bit_done && (state.bit_position == 3'd0);
        vote         = ones_new >= 3'(olfr_pkg::VOTE_MAJORITY);
        shift_new    = state.byte_shift | (8'(vote) << state.bit_position);
        bytes_new    = state.bytes_done + 1'b1;
        frame_last   = bytes_new >= olfr_pkg::frame_limit(cfg.frame_bytes);
    end

    // next state
    always_comb
    begin
        state_next            = state;
        state_next.prev_level = line_level;
        unique case (state.mode)
            olfr_pkg::MODE_IDLE:
            begin
                if (rise)
                begin
                    state_next      = olfr_pkg::clear_receive(state_next);
                    state_next.mode = olfr_pkg::MODE_HEADER;
                end
            end
            olfr_pkg::MODE_HEADER:
            begin
                if (rise)
                begin
                    state_next.tick_timer = '0;
                    state_next.mode       = olfr_pkg::MODE_IDLE;
                end
                else if (timer_inc >= cfg.header_ticks)
                begin
                    state_next.tick_timer = '0;
                    state_next.mode       = olfr_pkg::MODE_SKIP;
                end
                else
                begin
                    state_next.tick_timer = timer_inc;
                end
            end
            default:
            begin
                if (!in_receive)
                begin
                    state_next.tick_timer = timer_inc;
                end
                else
                begin
                    state_next.mode = olfr_pkg::MODE_RECEIVE;
                    if (sample_now)
                    begin
                        state_next.ones_seen     = ones_new;
                        state_next.sample_number = state.sample_number + 1'b1;
                    end
                    if (bit_done)
                    begin
                        state_next.ones_seen    = '0;
                        state_next.byte_shift   = shift_new;
                        state_next.bit_position = state.bit_position - 1'b1;
                    end
                    if (byte_done)
                    begin
                        state_next.bytes_done   = bytes_new;
                        state_next.byte_shift   = '0;
                        state_next.bit_position = 3'd7;
                    end
                    if (timer_rx_inc >= cfg.sample_ticks)
                        state_next.tick_timer = '0;
                    else
                        state_next.tick_timer = timer_rx_inc;
                    if (byte_done && frame_last)
                    begin
                        state_next      = olfr_pkg::clear_receive(state_next);
                        state_next.mode = olfr_pkg::MODE_IDLE;
                    end
                end
            end
        endcase
    end

    // result
    always_comb
    begin
        result.valid      = byte_done;
        result.data_byte  = shift_new;
        result.byte_index = state.bytes_done[olfr_pkg::INDEX_W-1:0];
        result.last_byte  = frame_last;
    end

endmodule

// ----- hw/rtl/olfr_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for optical_line_frame_receiver, attached by bind
// depends on optical_line_frame_receiver_macros.svh
`include "optical_line_frame_receiver_macros.svh"

module olfr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  data_byte,
    input logic [5:0]  byte_index,
    input logic        last_byte
);

    // a byte offered is held until taken
    `OLFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // a waiting byte keeps its payload
    `OLFR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(data_byte) && $stable(byte_index) && $stable(last_byte))
    // a new byte only follows an accepted sample
    `OLFR_ASSERT_NOW(a_out_from_in, $rose(out_valid), $past(in_valid && in_ready))
    // empty output register never blocks the input
    `OLFR_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
    // a stalled byte blocks the input
    `OLFR_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)

endmodule

bind optical_line_frame_receiver olfr_checker u_olfr_checker (.*);
